>>> hw/rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared widths, codes and transaction types for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int WORD_W      = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ZERO = '0;

	// command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// response status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_ENQUEUED = 2'd0;
	localparam status_t ST_DEQUEUED = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;
	localparam logic signed [WORD_W-1:0] ZERO_WORD  = '0;

	typedef struct packed {
		logic                     command;
		logic signed [WORD_W-1:0] item;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] item_out;
		status_t                  status;
	} rsp_t;

	// one write port and one read port of a stack memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_ctl_t;

endpackage

>>> hw/rtl/tsq_ram.sv
// ----------------------------------------------------------------------------
// tsq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tsq_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tsq_seq.sv
// ----------------------------------------------------------------------------
// tsq_seq
// Command sequencer: stack counters, transfer walk and response register.
// ----------------------------------------------------------------------------
module tsq_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  tsq_pkg::cmd_t                     cmd,
	output tsq_pkg::ram_ctl_t                 in_ctl,
	input  logic [tsq_pkg::WORD_W-1:0]        in_rdata,
	output tsq_pkg::ram_ctl_t                 out_ctl,
	input  logic [tsq_pkg::WORD_W-1:0]        out_rdata,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output tsq_pkg::rsp_t                     rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_XFER = 2'd1;
	localparam logic [1:0] S_DEQ  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                    state_q;
	logic [tsq_pkg::CNT_W-1:0]     in_count_q;
	logic [tsq_pkg::CNT_W-1:0]     out_count_q;
	logic                          xfer_s1;
	tsq_pkg::rsp_t                 res_q;
	logic                          rsp_valid_q;
	tsq_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic                          is_enq;
	logic                          in_full;
	logic                          enq_wr;
	logic                          xfer_rd;
	logic                          deq_rd;
	logic                          rsp_load;
	logic [tsq_pkg::CNT_W-1:0]     in_dec;
	logic [tsq_pkg::CNT_W-1:0]     out_dec;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign is_enq    = (cmd.command == tsq_pkg::CMD_ENQUEUE);
	assign in_full   = (in_count_q == tsq_pkg::CNT_FULL);
	assign in_dec    = in_count_q - tsq_pkg::CNT_ONE;
	assign out_dec   = out_count_q - tsq_pkg::CNT_ONE;

	assign enq_wr  = accept && is_enq && !in_full;
	assign xfer_rd = (state_q == S_XFER) && (in_count_q != tsq_pkg::CNT_ZERO);
	// pop the output stack on a dequeue when it holds words, or once the last transferred word has landed
	assign deq_rd  = (accept && !is_enq && (out_count_q != tsq_pkg::CNT_ZERO)) ||
		((state_q == S_XFER) && (in_count_q == tsq_pkg::CNT_ZERO) && !xfer_s1);
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		in_ctl.we     = enq_wr;
		in_ctl.waddr  = in_count_q[tsq_pkg::ADDR_W-1:0];
		in_ctl.wdata  = cmd.item;
		in_ctl.re     = xfer_rd;
		in_ctl.raddr  = in_dec[tsq_pkg::ADDR_W-1:0];
		out_ctl.we    = xfer_s1;
		out_ctl.waddr = out_count_q[tsq_pkg::ADDR_W-1:0];
		out_ctl.wdata = in_rdata;
		out_ctl.re    = deq_rd;
		out_ctl.raddr = out_dec[tsq_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_count_q  <= '0;
			out_count_q <= '0;
			xfer_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			xfer_s1 <= xfer_rd;

			if (enq_wr) begin
				in_count_q <= in_count_q + tsq_pkg::CNT_ONE;
			end else if (xfer_rd) begin
				in_count_q <= in_dec;
			end

			if (xfer_s1) begin
				out_count_q <= out_count_q + tsq_pkg::CNT_ONE;
			end else if (deq_rd) begin
				out_count_q <= out_dec;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_enq || deq_rd) begin
							state_q <= is_enq ? S_FIN : S_DEQ;
						end else if (in_count_q != tsq_pkg::CNT_ZERO) begin
							state_q <= S_XFER;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_XFER: begin
					if (deq_rd) begin
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.item_out <= is_enq ? tsq_pkg::ZERO_WORD : tsq_pkg::EMPTY_WORD;
			if (is_enq) begin
				res_q.status <= in_full ? tsq_pkg::ST_FULL : tsq_pkg::ST_ENQUEUED;
			end else begin
				res_q.status <= tsq_pkg::ST_EMPTY;
			end
		end else if (state_q == S_DEQ) begin
			res_q.item_out <= out_rdata;
			res_q.status   <= tsq_pkg::ST_DEQUEUED;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hw/rtl/two_stack_queue_top.sv
// A dequeue that finds the output stack empty first moves the input-stack words across.
// One command is in flight at a time; the next is accepted the cycle after the
// response enters the output register.
// The transfer moves one word a cycle, bound by the stack memories' read ports.
// arst_n clears both stack counts and the handshakes; memory contents are kept.
// ----------------------------------------------------------------------------
// two_stack_queue_top
// FIFO of signed words built from an input stack and an output stack.
// ----------------------------------------------------------------------------
module two_stack_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tsq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tsq_pkg::rsp_t rsp
);

	tsq_pkg::ram_ctl_t             in_ctl;
	tsq_pkg::ram_ctl_t             out_ctl;
	logic [tsq_pkg::WORD_W-1:0]    in_rdata;
	logic [tsq_pkg::WORD_W-1:0]    out_rdata;

	tsq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.in_ctl    (in_ctl),
		.in_rdata  (in_rdata),
		.out_ctl   (out_ctl),
		.out_rdata (out_rdata),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	tsq_ram #(
		.DEPTH (tsq_pkg::STACK_DEPTH),
		.WIDTH (tsq_pkg::WORD_W)
	) u_in_ram (
		.clk   (clk),
		.we    (in_ctl.we),
		.waddr (in_ctl.waddr),
		.wdata (in_ctl.wdata),
		.re    (in_ctl.re),
		.raddr (in_ctl.raddr),
		.rdata (in_rdata)
	);

	tsq_ram #(
		.DEPTH (tsq_pkg::STACK_DEPTH),
		.WIDTH (tsq_pkg::WORD_W)
	) u_out_ram (
		.clk   (clk),
		.we    (out_ctl.we),
		.waddr (out_ctl.waddr),
		.wdata (out_ctl.wdata),
		.re    (out_ctl.re),
		.raddr (out_ctl.raddr),
		.rdata (out_rdata)
	);

	// one command at a time: an accepted transaction blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command accepted while previous one in progress");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == tsq_pkg::ST_EMPTY)) |->
		(rsp.item_out == tsq_pkg::EMPTY_WORD))
		else $error("empty response without the empty word");

	a_enq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && ((rsp.status == tsq_pkg::ST_ENQUEUED) ||
		(rsp.status == tsq_pkg::ST_FULL))) |-> (rsp.item_out == tsq_pkg::ZERO_WORD))
		else $error("enqueue response carries a nonzero word");

endmodule
